[rtl/core/rshd_pkg.sv]
// Shared constants and types for the rotated sync header detector.
// No dependencies; imported by the top level.
`default_nettype none

package rshd_pkg;

   // Window and header geometry
   localparam int MAX_FRAME_SYMBOLS = 1024;
   localparam int HEADER_SYMBOLS    = 12;
   localparam int HEADER_8PSK       = HEADER_SYMBOLS * 2 / 3;

   localparam int ADDR_W  = $clog2(MAX_FRAME_SYMBOLS);
   localparam int LEN_W   = $clog2(MAX_FRAME_SYMBOLS + 1);
   localparam int RLCNT_W = $clog2(HEADER_SYMBOLS);
   localparam int SYM_W   = 3;
   localparam int FRAME_W = 11;
   localparam int MAXE_W  = 4;
   localparam int PAT_W   = 24;
   localparam int PAIR_W  = 2 * PAT_W;
   localparam int PAIRS   = 4;
   localparam int ROT_W   = 3;
   localparam int ROTS_8PSK = 8;
   localparam int ROTS_QPSK = 4;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = PAIR_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ERR = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAIR0   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAIR1   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAIR2   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAIR3   = 3'd6;

   localparam logic MODE_QPSK = 1'b0;
   localparam logic MODE_8PSK = 1'b1;

   localparam logic [MAXE_W-1:0] MAX_ERR_RESET = 4'd2;
   localparam int                FRAME_RESET   = 688;

   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [PAIR_W-1:0] pair_type;

endpackage

`default_nettype wire

[rtl/core/rshd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rshd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/rotated_sync_header_detector.sv]
// Rotated sync header detector top level: symbol history RAM, header candidate
// shift line, rotated pattern compare. Uses rshd_pkg, rshd_ram.
// An accepted beat goes through the compare stage register, then the result register.
// Throughput: one beat per cycle; req_tready drops only while compare stage and result
// register are both full with rsp_tready low, and while a frame_symbols write is reloading.
// Reset is synchronous; the history RAM is not cleared, a fill count reads it as zeros.
`default_nettype none

module rotated_sync_header_detector
   import rshd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request side
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [2:0] symbol
   // result side
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [7:0]            rsp_tdata,   // [0] header_found, [3:1] rotation
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic                mode_ff, mode_in;
   logic [MAXE_W-1:0]   max_err_ff, max_err_in;
   logic [LEN_W-1:0]    len_ff, len_in;         // saturated window length
   pair_type            pair_ff [PAIRS];
   pair_type            pair_in [PAIRS];
   logic [FRAME_W-1:0]  frame_wr;

   always_comb begin
      mode_in    = mode_ff;
      max_err_in = max_err_ff;
      len_in     = len_ff;
      pair_in    = pair_ff;
      frame_wr   = csr_wdata[FRAME_W-1:0];
      if (csr_we) begin
         case (csr_addr)
            CSR_MODE:    mode_in    = csr_wdata[0];
            CSR_MAX_ERR: max_err_in = csr_wdata[MAXE_W-1:0];
            CSR_FRAME: begin
               // clamp to [header length, history depth]
               if (32'(frame_wr) < 32'(HEADER_SYMBOLS)) begin
                  len_in = LEN_W'(HEADER_SYMBOLS);
               end else if (32'(frame_wr) > 32'(MAX_FRAME_SYMBOLS)) begin
                  len_in = LEN_W'(MAX_FRAME_SYMBOLS);
               end else begin
                  len_in = LEN_W'(frame_wr);
               end
            end
            CSR_PAIR0:   pair_in[0] = csr_wdata[PAIR_W-1:0];
            CSR_PAIR1:   pair_in[1] = csr_wdata[PAIR_W-1:0];
            CSR_PAIR2:   pair_in[2] = csr_wdata[PAIR_W-1:0];
            CSR_PAIR3:   pair_in[3] = csr_wdata[PAIR_W-1:0];
            default:     ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_QPSK;
         max_err_ff <= MAX_ERR_RESET;
         len_ff     <= LEN_W'(FRAME_RESET);
         for (int p = 0; p < PAIRS; p++) begin
            pair_ff[p] <= '0;
         end
      end else begin
         mode_ff    <= mode_in;
         max_err_ff <= max_err_in;
         len_ff     <= len_in;
         pair_ff    <= pair_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake / stage control
   // ---------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_reload_ff, s1_reload_in;   // reload read, no result
   sym_type       s1_sym_ff, s1_sym_in;
   logic          s1_bypass_ff, s1_bypass_in;   // needed symbol is this beat
   logic          s1_hit_ff, s1_hit_in;         // RAM entry has been written
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [ROT_W-1:0] rsp_rot_ff, rsp_rot_in;

   logic          rl_active_ff, rl_active_in;
   logic [RLCNT_W-1:0] rl_cnt_ff, rl_cnt_in;

   logic          out_free, s1_adv, s1_free, accept, rl_issue;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && (s1_reload_ff || out_free);
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign req_tready = s1_free && !rl_active_ff;
   assign accept     = req_tvalid && req_tready;
   assign rl_issue   = rl_active_ff && s1_free;

   // ---------------------------------------------------------------
   // History pointer, fill count, RAM read address
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] wp_ff, wp_in, wp_next, base_wp, rd_addr;
   logic [LEN_W-1:0]  count_ff, count_in, count_next, base_cnt, age, addr_wrap;
   sym_type           rd_data;
   logic              rd_en;

   assign wp_next    = (wp_ff == ADDR_W'(MAX_FRAME_SYMBOLS - 1)) ? '0
                                                              : wp_ff + ADDR_W'(1);
   assign count_next = (count_ff == LEN_W'(MAX_FRAME_SYMBOLS)) ? count_ff
                                                              : count_ff + LEN_W'(1);

   always_comb begin
      // reload reads relative to the current newest, beats after their own push
      base_wp  = rl_issue ? wp_ff    : wp_next;
      base_cnt = rl_issue ? count_ff : count_next;
      age      = rl_issue ? len_ff - LEN_W'(1) - LEN_W'(rl_cnt_ff)
                          : len_ff - LEN_W'(HEADER_SYMBOLS);
      addr_wrap = LEN_W'(base_wp) + LEN_W'(MAX_FRAME_SYMBOLS) - age;
      if (LEN_W'(base_wp) >= age) begin
         rd_addr = base_wp - age[ADDR_W-1:0];
      end else begin
         rd_addr = addr_wrap[ADDR_W-1:0];
      end
      rd_en = accept || rl_issue;
   end

   assign wp_in    = accept ? wp_next    : wp_ff;
   assign count_in = accept ? count_next : count_ff;

   rshd_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_FRAME_SYMBOLS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_next),
      .wr_data (req_tdata[SYM_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // Stage 1 capture and reload sequencer
   // ---------------------------------------------------------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_reload_in = s1_reload_ff;
      s1_sym_in    = s1_sym_ff;
      s1_bypass_in = s1_bypass_ff;
      s1_hit_in    = s1_hit_ff;
      if (rd_en) begin
         s1_valid_in  = 1'b1;
         s1_reload_in = rl_issue;
         s1_sym_in    = req_tdata[SYM_W-1:0];
         s1_bypass_in = !rl_issue && (age == '0);
         s1_hit_in    = age < base_cnt;
      end else if (s1_adv) begin
         s1_valid_in  = 1'b0;
      end

      rl_active_in = rl_active_ff;
      rl_cnt_in    = rl_cnt_ff;
      if (csr_we && (csr_addr == CSR_FRAME)) begin
         // new window length: refetch the whole candidate
         rl_active_in = 1'b1;
         rl_cnt_in    = '0;
      end else if (rl_issue) begin
         if (rl_cnt_ff == RLCNT_W'(HEADER_SYMBOLS - 1)) begin
            rl_active_in = 1'b0;
         end
         rl_cnt_in = rl_cnt_ff + RLCNT_W'(1);
      end
   end

   // ---------------------------------------------------------------
   // Header candidate: slot 0 is the oldest symbol of the window
   // ---------------------------------------------------------------
   sym_type cand_ff    [HEADER_SYMBOLS];
   sym_type cand_shift [HEADER_SYMBOLS];
   sym_type new_slot;

   always_comb begin
      if (s1_bypass_ff) begin
         new_slot = s1_sym_ff;
      end else if (s1_hit_ff) begin
         new_slot = rd_data;
      end else begin
         new_slot = '0;
      end
      for (int i = 0; i < HEADER_SYMBOLS - 1; i++) begin
         cand_shift[i] = cand_ff[i+1];
      end
      cand_shift[HEADER_SYMBOLS-1] = new_slot;
   end

   // ---------------------------------------------------------------
   // Rotated pattern compare, lowest matching rotation wins
   // ---------------------------------------------------------------
   logic             match_found;
   logic [ROT_W-1:0] match_rot;

   always_comb begin
      logic [PAT_W-1:0]          half;
      logic [HEADER_SYMBOLS-1:0] mism;
      logic                      rot_used;
      match_found = 1'b0;
      match_rot   = '0;
      for (int r = ROTS_8PSK - 1; r >= 0; r--) begin
         half     = pair_ff[r >> 1][(r & 1) * PAT_W +: PAT_W];
         mism     = '0;
         rot_used = (mode_ff == MODE_8PSK) || (r < ROTS_QPSK);
         if (mode_ff == MODE_8PSK) begin
            for (int i = 0; i < HEADER_8PSK; i++) begin
               mism[i] = cand_shift[i] != half[i*SYM_W +: SYM_W];
            end
         end else begin
            // out-of-range QPSK symbols never match the 2-bit pattern
            for (int i = 0; i < HEADER_SYMBOLS; i++) begin
               mism[i] = cand_shift[i] != {1'b0, half[i*2 +: 2]};
            end
         end
         if (rot_used && (32'($countones(mism)) <= 32'(max_err_ff))) begin
            match_found = 1'b1;
            match_rot   = ROT_W'(r);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_rot_in   = rsp_rot_ff;
      if (s1_adv && !s1_reload_ff) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = match_found;
         rsp_rot_in   = match_rot;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s1_reload_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rl_active_ff <= 1'b0;
         rl_cnt_ff    <= '0;
         for (int i = 0; i < HEADER_SYMBOLS; i++) begin
            cand_ff[i] <= '0;
         end
      end else begin
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         s1_reload_ff <= s1_reload_in;
         rsp_valid_ff <= rsp_valid_in;
         rl_active_ff <= rl_active_in;
         rl_cnt_ff    <= rl_cnt_in;
         if (s1_adv) begin
            cand_ff <= cand_shift;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_sym_ff    <= s1_sym_in;
      s1_bypass_ff <= s1_bypass_in;
      s1_hit_ff    <= s1_hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rot_ff   <= rsp_rot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_rot_ff, rsp_found_ff};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rot_zero_if_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_rot_ff == '0))
      else $error("rotation nonzero without a header");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(MAX_FRAME_SYMBOLS))
      else $error("fill count past history depth");

   a_reload_start: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_addr == CSR_FRAME)) |=> (rl_active_ff && (rl_cnt_ff == '0)))
      else $error("frame length write did not restart candidate reload");

   a_reload_cnt: assert property (@(posedge clock) disable iff (reset)
      rl_active_ff |-> (32'(rl_cnt_ff) < 32'(HEADER_SYMBOLS)))
      else $error("reload counter out of range");

   a_beat_to_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> (s1_valid_ff && !s1_reload_ff))
      else $error("accepted beat not captured in compare stage");

endmodule

`default_nettype wire
